@@ rtl/idll_pkg.sv @@
package idll_pkg;

  localparam int unsigned MAX_NODES = 1024;
  localparam int unsigned ID_W      = 11;

  typedef logic [ID_W-1:0] id_t;

  localparam id_t ID_NONE = '0;
  localparam id_t ID_MAX  = ID_W'(MAX_NODES);

  typedef enum logic [1:0] {
    MODE_INS_LEFT  = 2'd0,
    MODE_INS_RIGHT = 2'd1,
    MODE_DELETE    = 2'd2,
    MODE_READ      = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    STS_DONE    = 2'd0,
    STS_SKIPPED = 2'd1,
    STS_BAD_ID  = 2'd2,
    STS_FULL    = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_LINK,
    S_FIX
  } state_e;

  typedef struct packed {
    mode_e mode;
    id_t   anchor_id;
    id_t   target_id;
  } req_t;

  typedef struct packed {
    status_e status;
    id_t     node_id;
    logic    last;
  } rsp_t;

  // One list entry: removed flag and both links.
  typedef struct packed {
    logic removed;
    id_t  left;
    id_t  right;
  } node_t;

  typedef struct packed {
    logic  re;
    id_t   raddr;
    logic  we;
    id_t   waddr;
    node_t wdata;
  } mem_req_t;

endpackage

@@ rtl/idll_mem.sv @@
module idll_mem (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  idll_pkg::mem_req_t req_i,
  output idll_pkg::node_t   rdata_o
);

  idll_pkg::node_t mem_q [0:idll_pkg::MAX_NODES];
  idll_pkg::node_t rdata_q;
  logic            rd_one_q;
  logic            n1_valid_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  // Node 1 exists from reset; its entry reads as zero until first written.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n1_valid_q <= 1'b0;
      rd_one_q   <= 1'b0;
    end else begin
      if (req_i.we && req_i.waddr == idll_pkg::ID_W'(1)) begin
        n1_valid_q <= 1'b1;
      end
      if (req_i.re) begin
        rd_one_q <= (req_i.raddr == idll_pkg::ID_W'(1));
      end
    end
  end

  assign rdata_o = (rd_one_q && !n1_valid_q) ? '0 : rdata_q;

endmodule

@@ rtl/idll_ctrl.sv @@
module idll_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  idll_pkg::req_t     req_i,
  output idll_pkg::rsp_t     rsp_o,
  output logic               done_o,
  output idll_pkg::mem_req_t mem_o,
  input  idll_pkg::node_t    rdata_i
);

  idll_pkg::state_e state_q, state_d;
  idll_pkg::req_t   req_q, req_d;
  idll_pkg::node_t  prim_q, prim_d;
  idll_pkg::id_t    nb_q, nb_d;
  idll_pkg::id_t    cur_q, cur_d;
  idll_pkg::id_t    head_q, head_d;
  idll_pkg::id_t    next_id_q, next_id_d;
  idll_pkg::id_t    cursor_q, cursor_d;
  idll_pkg::rsp_t   rsp_q, rsp_d;
  logic             done_q, done_d;

  logic             accept;
  logic             is_ins;
  logic             ins_left;
  logic             full;
  logic             anchor_ok;
  logic             target_ok;
  idll_pkg::id_t    cur_sel;
  idll_pkg::id_t    start_addr;
  idll_pkg::id_t    nb_id;

  assign accept   = start && (state_q == idll_pkg::S_IDLE);
  assign is_ins   = (req_q.mode == idll_pkg::MODE_INS_LEFT)
                 || (req_q.mode == idll_pkg::MODE_INS_RIGHT);
  assign ins_left = (req_q.mode == idll_pkg::MODE_INS_LEFT);
  assign full     = (next_id_q > idll_pkg::ID_MAX);
  assign anchor_ok = (req_q.anchor_id != idll_pkg::ID_NONE) && (req_q.anchor_id < next_id_q);
  assign target_ok = (req_q.target_id != idll_pkg::ID_NONE) && (req_q.target_id < next_id_q);
  assign cur_sel  = (cursor_q != idll_pkg::ID_NONE) ? cursor_q : head_q;
  assign nb_id    = ins_left ? rdata_i.left : rdata_i.right;

  always_comb begin
    unique case (req_i.mode)
      idll_pkg::MODE_INS_LEFT,
      idll_pkg::MODE_INS_RIGHT: start_addr = req_i.anchor_id;
      idll_pkg::MODE_DELETE:    start_addr = req_i.target_id;
      default:                  start_addr = cur_sel;
    endcase
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      idll_pkg::S_IDLE: begin
        if (accept) state_d = idll_pkg::S_CHECK;
      end
      idll_pkg::S_CHECK: begin
        if (is_ins) begin
          state_d = (full || !anchor_ok || rdata_i.removed) ? idll_pkg::S_IDLE
                                                             : idll_pkg::S_LINK;
        end else if (req_q.mode == idll_pkg::MODE_DELETE) begin
          state_d = (!target_ok || rdata_i.removed) ? idll_pkg::S_IDLE : idll_pkg::S_LINK;
        end else begin
          state_d = idll_pkg::S_IDLE;
        end
      end
      idll_pkg::S_LINK: state_d = idll_pkg::S_FIX;
      idll_pkg::S_FIX:  state_d = idll_pkg::S_IDLE;
      default:          state_d = idll_pkg::S_IDLE;
    endcase
  end

  // Memory traffic and datapath.
  always_comb begin
    req_d     = req_q;
    prim_d    = prim_q;
    nb_d      = nb_q;
    cur_d     = cur_q;
    head_d    = head_q;
    next_id_d = next_id_q;
    cursor_d  = cursor_q;
    rsp_d     = rsp_q;
    done_d    = 1'b0;
    mem_o     = '0;

    unique case (state_q)
      idll_pkg::S_IDLE: begin
        if (accept) begin
          req_d       = req_i;
          cur_d       = cur_sel;
          mem_o.re    = (start_addr <= idll_pkg::ID_MAX);
          mem_o.raddr = start_addr;
        end
      end

      idll_pkg::S_CHECK: begin
        if (is_ins) begin
          cursor_d = idll_pkg::ID_NONE;
          if (full || !anchor_ok || rdata_i.removed) begin
            rsp_d  = '{status: full ? idll_pkg::STS_FULL : idll_pkg::STS_BAD_ID,
                       node_id: idll_pkg::ID_NONE, last: 1'b0};
            done_d = 1'b1;
          end else begin
            // Link the fresh node, then fetch the neighbor on the anchor's side.
            mem_o.we            = 1'b1;
            mem_o.waddr         = next_id_q;
            mem_o.wdata.removed = 1'b0;
            mem_o.wdata.left    = ins_left ? nb_id : req_q.anchor_id;
            mem_o.wdata.right   = ins_left ? req_q.anchor_id : nb_id;
            mem_o.re            = 1'b1;
            mem_o.raddr         = nb_id;
            prim_d              = rdata_i;
            if (ins_left) begin
              prim_d.left = next_id_q;
              if (nb_id == idll_pkg::ID_NONE) head_d = next_id_q;
            end else begin
              prim_d.right = next_id_q;
            end
            nb_d      = nb_id;
            next_id_d = next_id_q + idll_pkg::ID_W'(1);
            rsp_d     = '{status: idll_pkg::STS_DONE, node_id: next_id_q, last: 1'b0};
          end
        end else if (req_q.mode == idll_pkg::MODE_DELETE) begin
          cursor_d = idll_pkg::ID_NONE;
          rsp_d    = '{status: idll_pkg::STS_DONE, node_id: idll_pkg::ID_NONE, last: 1'b0};
          if (!target_ok) begin
            rsp_d.status = idll_pkg::STS_BAD_ID;
            done_d       = 1'b1;
          end else if (rdata_i.removed) begin
            rsp_d.status = idll_pkg::STS_SKIPPED;
            done_d       = 1'b1;
          end else begin
            // Mark removed, then fetch the left neighbor.
            mem_o.we            = 1'b1;
            mem_o.waddr         = req_q.target_id;
            mem_o.wdata         = rdata_i;
            mem_o.wdata.removed = 1'b1;
            mem_o.re            = 1'b1;
            mem_o.raddr         = rdata_i.left;
            prim_d              = rdata_i;
            if (head_q == req_q.target_id) head_d = rdata_i.right;
          end
        end else begin
          if (cur_q == idll_pkg::ID_NONE) begin
            rsp_d    = '{status: idll_pkg::STS_DONE, node_id: idll_pkg::ID_NONE, last: 1'b1};
            cursor_d = idll_pkg::ID_NONE;
          end else begin
            rsp_d    = '{status: idll_pkg::STS_DONE, node_id: cur_q,
                         last: (rdata_i.right == idll_pkg::ID_NONE)};
            cursor_d = rdata_i.right;
          end
          done_d = 1'b1;
        end
      end

      idll_pkg::S_LINK: begin
        if (is_ins) begin
          // Point the neighbor back at the fresh node.
          mem_o.we    = (nb_q != idll_pkg::ID_NONE);
          mem_o.waddr = nb_q;
          mem_o.wdata = rdata_i;
          if (ins_left) begin
            mem_o.wdata.right = rsp_q.node_id;
          end else begin
            mem_o.wdata.left = rsp_q.node_id;
          end
        end else begin
          // Left neighbor skips over the target; fetch the right one.
          mem_o.we          = (prim_q.left != idll_pkg::ID_NONE);
          mem_o.waddr       = prim_q.left;
          mem_o.wdata       = rdata_i;
          mem_o.wdata.right = prim_q.right;
          mem_o.re          = 1'b1;
          mem_o.raddr       = prim_q.right;
        end
      end

      idll_pkg::S_FIX: begin
        if (is_ins) begin
          mem_o.we    = 1'b1;
          mem_o.waddr = req_q.anchor_id;
          mem_o.wdata = prim_q;
        end else begin
          mem_o.we         = (prim_q.right != idll_pkg::ID_NONE);
          mem_o.waddr      = prim_q.right;
          mem_o.wdata      = rdata_i;
          mem_o.wdata.left = prim_q.left;
        end
        done_d = 1'b1;
      end

      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= idll_pkg::S_IDLE;
      head_q    <= idll_pkg::ID_W'(1);
      next_id_q <= idll_pkg::ID_W'(2);
      cursor_q  <= idll_pkg::ID_NONE;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      head_q    <= head_d;
      next_id_q <= next_id_d;
      cursor_q  <= cursor_d;
      done_q    <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q  <= req_d;
    prim_q <= prim_d;
    nb_q   <= nb_d;
    cur_q  <= cur_d;
    rsp_q  <= rsp_d;
  end

  assign busy   = (state_q != idll_pkg::S_IDLE);
  assign rsp_o  = rsp_q;
  assign done_o = done_q;

endmodule

@@ rtl/indexed_doubly_linked_list.sv @@
// Indexed doubly linked list of numbered nodes (ids 1..1024, 0 means none).
//
// Request channel: drive req_i and raise start; the request is taken at a
// rising edge where start is high and busy is low. Modes: insert left or
// right of an anchor, delete a target, read the next node of an in-order walk.
// Response channel: rsp_o is valid for exactly one cycle while done_o is high.
// The receiver cannot stall; a response must be taken in that cycle.
//
// Steps after the accepting edge, before the cycle done_o is high:
//   successful insert or delete: check, link, fix, then response
//   read, skipped delete, error: check, then response
// busy drops in the cycle done_o is high, so a new request can be taken there;
// a new request is never taken before the last one has responded. Up to three
// entries are written per request through the single write port of the node
// memory, one in each of the check, link and fix states.
//
// Reset: node 1 is the only node and the head, the next new id is 2 and the
// walk is idle. The node memory is never cleared: an entry's data is used only
// after it has been written, and node 1 reads as zero until first written.
module indexed_doubly_linked_list (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  idll_pkg::req_t req_i,
  output idll_pkg::rsp_t rsp_o,
  output logic           done_o
);

  idll_pkg::mem_req_t mem_req;
  idll_pkg::node_t    mem_rdata;

  // Sequencer: checks ids, tracks head, next id and walk cursor.
  idll_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .req_i   (req_i),
    .rsp_o   (rsp_o),
    .done_o  (done_o),
    .mem_o   (mem_req),
    .rdata_i (mem_rdata)
  );

  // Node store: removed flag plus both links, one read and one write a cycle.
  idll_mem u_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

endmodule

@@ rtl/idll_checker.sv @@
module idll_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start,
  input logic           busy,
  input idll_pkg::rsp_t rsp_o,
  input logic           done_o
);

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("response while busy");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("request taken without going busy");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("two responses back to back");

  a_last_read_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.last) |-> (rsp_o.status == idll_pkg::STS_DONE))
    else $error("last flag with failing status");

  a_fail_no_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (rsp_o.status == idll_pkg::STS_FULL || rsp_o.status == idll_pkg::STS_BAD_ID))
      |-> (rsp_o.node_id == idll_pkg::ID_NONE))
    else $error("failed request returned a node id");

endmodule

bind indexed_doubly_linked_list idll_checker u_idll_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .rsp_o  (rsp_o),
  .done_o (done_o)
);
